// ===== sv/bps_pkg.sv =====
// buzzer pattern sequencer package: beat types, command and pattern codes,
// segment durations and the preset lookup tables
// no dependencies
package bps_pkg;

    // parameter defaults
    localparam int DURATION_BITS_DEF = 16;
    localparam int REPEAT_BITS_DEF   = 32;

    // input beat kinds
    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_BLINK     = 3'd1;
    localparam logic [2:0] KIND_PRESET    = 3'd2;
    localparam logic [2:0] KIND_STOP      = 3'd3;
    localparam logic [2:0] KIND_FORCE_ON  = 3'd4;
    localparam logic [2:0] KIND_FORCE_OFF = 3'd5;

    // preset pattern codes
    localparam logic [3:0] PAT_INIT      = 4'd0;
    localparam logic [3:0] PAT_STOP      = 4'd1;
    localparam logic [3:0] PAT_WARN1     = 4'd2;
    localparam logic [3:0] PAT_WARN2     = 4'd3;
    localparam logic [3:0] PAT_WARN3     = 4'd4;
    localparam logic [3:0] PAT_HEARTBEAT = 4'd5;
    localparam logic [3:0] PAT_ERROR     = 4'd6;
    localparam logic [3:0] PAT_SUCCESS   = 4'd7;
    localparam logic [3:0] PAT_ALARM     = 4'd8;
    localparam logic [3:0] PAT_SOS       = 4'd9;
    localparam logic [3:0] PAT_COUNT     = 4'd10;

    // segment durations in ms
    localparam logic [11:0] MS_5    = 12'd5;
    localparam logic [11:0] MS_25   = 12'd25;
    localparam logic [11:0] MS_50   = 12'd50;
    localparam logic [11:0] MS_100  = 12'd100;
    localparam logic [11:0] MS_200  = 12'd200;
    localparam logic [11:0] MS_300  = 12'd300;
    localparam logic [11:0] MS_400  = 12'd400;
    localparam logic [11:0] MS_950  = 12'd950;
    localparam logic [11:0] MS_1000 = 12'd1000;
    localparam logic [11:0] MS_2000 = 12'd2000;

    // pulse and burst counts
    localparam logic [4:0] WARN1_PULSES = 5'd20;
    localparam logic [3:0] WARN1_BURSTS = 4'd10;
    localparam logic [4:0] WARN3_PULSES = 5'd10;
    localparam logic [4:0] ERROR_EXTRA  = 5'd2;
    localparam logic [4:0] SOS_SYMBOLS  = 5'd3;
    localparam logic [3:0] SOS_LETTERS  = 4'd3;

    // sequencer mode
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_BLINK  = 3'b010,
        MODE_PRESET = 3'b100
    } t_mode;

    // input beat
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] on_time;
        logic [15:0] off_time;
        logic [3:0]  pattern;
        logic [31:0] repeat_count;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic pin_level;
        logic sounding;
        logic busy_res;
    } t_out_beat;

    // first ON segment of each preset
    function automatic logic [11:0] first_on_ms(input logic [3:0] pat);
        logic [11:0] ms;
        case (pat)
            PAT_INIT:      ms = MS_1000;
            PAT_STOP:      ms = MS_100;
            PAT_WARN1:     ms = MS_5;
            PAT_WARN2:     ms = MS_100;
            PAT_WARN3:     ms = MS_25;
            PAT_HEARTBEAT: ms = MS_50;
            PAT_ERROR:     ms = MS_200;
            PAT_SUCCESS:   ms = MS_100;
            PAT_ALARM:     ms = MS_2000;
            PAT_SOS:       ms = MS_100;
            default:       ms = '0;
        endcase
        return ms;
    endfunction

    // ON time of the plain on/off presets
    function automatic logic [11:0] pair_on_ms(input logic [3:0] pat);
        logic [11:0] ms;
        case (pat)
            PAT_INIT:      ms = MS_1000;
            PAT_WARN2:     ms = MS_100;
            PAT_HEARTBEAT: ms = MS_50;
            PAT_ALARM:     ms = MS_2000;
            default:       ms = '0;
        endcase
        return ms;
    endfunction

    // OFF time of the plain on/off presets
    function automatic logic [11:0] pair_off_ms(input logic [3:0] pat);
        logic [11:0] ms;
        case (pat)
            PAT_INIT:      ms = MS_100;
            PAT_WARN2:     ms = MS_100;
            PAT_HEARTBEAT: ms = MS_950;
            PAT_ALARM:     ms = MS_200;
            default:       ms = '0;
        endcase
        return ms;
    endfunction

endpackage

// ===== sv/buzzer_pattern_sequencer.sv =====
// a beat accepted into the input register is processed when the result side
// can advance, and its result beat is then held in the result register
// throughput: one beat per cycle unless the receiver stalls; the registers decouple
// the sides, so an empty input register takes a beat while a result waits
// reset (i_rst_n low, synchronous): idle, buzzer off, active_level high
// top level: input register, sequencer core, result register and config
// depends on bps_pkg and bps_core
module buzzer_pattern_sequencer #(
    parameter int DURATION_BITS = bps_pkg::DURATION_BITS_DEF,
    parameter int REPEAT_BITS   = bps_pkg::REPEAT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bps_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bps_pkg::t_out_beat  o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);

    logic               r_in_valid;
    bps_pkg::t_in_beat  r_in;
    logic               r_out_valid;
    bps_pkg::t_out_beat r_out;
    logic               r_active_level;
    bps_pkg::t_out_beat core_res;
    logic               advance;
    logic               fire;
    logic               in_accept;

    // handshake
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= 1'b1;
        end else if (i_cfg_we) begin
            r_active_level <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    bps_core #(
        .DURATION_BITS (DURATION_BITS),
        .REPEAT_BITS   (REPEAT_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_beat         (r_in),
        .i_active_level (r_active_level),
        .o_res          (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // every processed beat shows up as a result beat
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed beat did not produce a result");

    // pin level follows polarity of the sounding flag
    a_polarity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_out.pin_level == !(r_out.sounding ^ $past(r_active_level))))
        else $error("pin level does not match polarity");

    // stop leaves a busy buzzer quiet and idle
    a_stop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_in.kind == bps_pkg::KIND_STOP) && $past(r_out.busy_res)
         && $past(r_out_valid) && !$past(fire))
        |=> (!r_out.busy_res && !r_out.sounding))
        else $error("stop left the buzzer busy or sounding");

    // input side only stalls while a beat is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with no beat held");

endmodule

// ===== sv/bps_core.sv =====
// buzzer sequencer state and its one-beat update: mode, level, countdown,
// repeat count and the preset pattern position
// depends on bps_pkg
module bps_core #(
    parameter int DURATION_BITS = bps_pkg::DURATION_BITS_DEF,
    parameter int REPEAT_BITS   = bps_pkg::REPEAT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  bps_pkg::t_in_beat   i_beat,
    input  logic                i_active_level,
    output bps_pkg::t_out_beat  o_res
);

    function automatic logic [DURATION_BITS-1:0] dur(input logic [11:0] ms);
        return DURATION_BITS'(ms);
    endfunction

    // state registers
    bps_pkg::t_mode           r_mode,    n_mode;
    logic                     r_level,   n_level;
    logic [DURATION_BITS-1:0] r_cd,      n_cd;
    logic [REPEAT_BITS-1:0]   r_rep,     n_rep;
    logic [DURATION_BITS-1:0] r_on_t,    n_on_t;
    logic [DURATION_BITS-1:0] r_off_t,   n_off_t;
    logic [3:0]               r_pat,     n_pat;
    logic [1:0]               r_seg,     n_seg;
    logic [4:0]               r_inner,   n_inner;
    logic [3:0]               r_outer,   n_outer;

    // shared helpers
    logic [DURATION_BITS-1:0] cd_dec;
    logic                     last_pass;
    logic [REPEAT_BITS-1:0]   rep_dec;
    logic [4:0]               inner_inc;
    logic [3:0]               outer_inc;

    assign cd_dec    = (r_cd != '0) ? r_cd - DURATION_BITS'(1) : r_cd;
    assign last_pass = (r_rep == REPEAT_BITS'(1));
    assign rep_dec   = (r_rep > REPEAT_BITS'(1)) ? r_rep - REPEAT_BITS'(1) : r_rep;
    assign inner_inc = r_inner + 5'd1;
    assign outer_inc = r_outer + 4'd1;

    // next state for one beat
    always_comb begin
        n_mode  = r_mode;
        n_level = r_level;
        n_cd    = r_cd;
        n_rep   = r_rep;
        n_on_t  = r_on_t;
        n_off_t = r_off_t;
        n_pat   = r_pat;
        n_seg   = r_seg;
        n_inner = r_inner;
        n_outer = r_outer;

        case (i_beat.kind)
            bps_pkg::KIND_TICK: begin
                if (r_mode != bps_pkg::MODE_IDLE) begin
                    n_cd = cd_dec;
                    if (cd_dec == '0) begin
                        if (r_mode == bps_pkg::MODE_BLINK) begin
                            // blink: ON phase then OFF phase
                            if (!r_seg[0]) begin
                                n_seg   = 2'd1;
                                n_level = 1'b0;
                                n_cd    = r_off_t;
                            end else if (last_pass) begin
                                n_mode  = bps_pkg::MODE_IDLE;
                                n_level = 1'b0;
                            end else begin
                                n_rep   = rep_dec;
                                n_seg   = 2'd0;
                                n_level = 1'b1;
                                n_cd    = r_on_t;
                            end
                        end else begin
                            case (r_pat)
                                bps_pkg::PAT_INIT, bps_pkg::PAT_WARN2,
                                bps_pkg::PAT_HEARTBEAT, bps_pkg::PAT_ALARM: begin
                                    if (r_level) begin
                                        n_level = 1'b0;
                                        n_cd    = dur(bps_pkg::pair_off_ms(r_pat));
                                    end else if (last_pass) begin
                                        n_mode  = bps_pkg::MODE_IDLE;
                                        n_level = 1'b0;
                                    end else begin
                                        n_rep   = rep_dec;
                                        n_level = 1'b1;
                                        n_cd    = dur(bps_pkg::pair_on_ms(r_pat));
                                    end
                                end
                                bps_pkg::PAT_STOP: begin
                                    if (!r_seg[0]) begin
                                        n_level = 1'b0;
                                        n_cd    = dur(bps_pkg::MS_100);
                                        n_seg   = r_seg + 2'd1;
                                    end else if (r_seg == 2'd3) begin
                                        if (last_pass) begin
                                            n_mode  = bps_pkg::MODE_IDLE;
                                            n_level = 1'b0;
                                        end else begin
                                            n_rep   = rep_dec;
                                            n_seg   = 2'd0;
                                            n_level = 1'b1;
                                            n_cd    = dur(bps_pkg::MS_100);
                                        end
                                    end else begin
                                        n_level = 1'b1;
                                        n_cd    = dur(bps_pkg::MS_100);
                                        n_seg   = r_seg + 2'd1;
                                    end
                                end
                                bps_pkg::PAT_WARN1: begin
                                    if (r_inner < bps_pkg::WARN1_PULSES) begin
                                        n_level = !r_level;
                                        n_cd    = dur(bps_pkg::MS_5);
                                        if (!r_level) begin
                                            n_inner = inner_inc;
                                        end
                                    end else if (r_level) begin
                                        n_level = 1'b0;
                                        n_cd    = dur(bps_pkg::MS_200);
                                    end else begin
                                        n_inner = '0;
                                        n_outer = outer_inc;
                                        if (outer_inc >= bps_pkg::WARN1_BURSTS &&
                                            last_pass) begin
                                            n_mode  = bps_pkg::MODE_IDLE;
                                            n_level = 1'b0;
                                        end else begin
                                            if (outer_inc >= bps_pkg::WARN1_BURSTS) begin
                                                n_rep   = rep_dec;
                                                n_outer = '0;
                                            end
                                            n_level = 1'b1;
                                            n_cd    = dur(bps_pkg::MS_5);
                                        end
                                    end
                                end
                                bps_pkg::PAT_WARN3: begin
                                    if (r_inner < bps_pkg::WARN3_PULSES) begin
                                        n_level = !r_level;
                                        n_cd    = dur(bps_pkg::MS_25);
                                        if (!r_level) begin
                                            n_inner = inner_inc;
                                        end
                                    end else if (last_pass) begin
                                        n_mode  = bps_pkg::MODE_IDLE;
                                        n_level = 1'b0;
                                    end else begin
                                        n_rep   = rep_dec;
                                        n_inner = '0;
                                        n_level = 1'b1;
                                        n_cd    = dur(bps_pkg::MS_25);
                                    end
                                end
                                bps_pkg::PAT_ERROR: begin
                                    if (r_level) begin
                                        n_level = 1'b0;
                                        n_cd    = dur(bps_pkg::MS_100);
                                    end else if (r_seg != 2'd0) begin
                                        // end of the pause before a further pass
                                        n_seg   = 2'd0;
                                        n_level = 1'b1;
                                        n_cd    = dur(bps_pkg::MS_200);
                                    end else if (r_inner < bps_pkg::ERROR_EXTRA) begin
                                        n_inner = inner_inc;
                                        n_level = 1'b1;
                                        n_cd    = dur(bps_pkg::MS_200);
                                    end else begin
                                        n_inner = '0;
                                        if (last_pass) begin
                                            n_mode  = bps_pkg::MODE_IDLE;
                                            n_level = 1'b0;
                                        end else begin
                                            n_rep   = rep_dec;
                                            n_seg   = 2'd1;
                                            n_level = 1'b0;
                                            n_cd    = dur(bps_pkg::MS_1000);
                                        end
                                    end
                                end
                                bps_pkg::PAT_SUCCESS: begin
                                    if (r_seg == 2'd0) begin
                                        n_level = 1'b0;
                                        n_cd    = dur(bps_pkg::MS_50);
                                        n_seg   = 2'd1;
                                    end else if (r_seg == 2'd1) begin
                                        n_level = 1'b1;
                                        n_cd    = dur(bps_pkg::MS_400);
                                        n_seg   = 2'd2;
                                    end else if (last_pass) begin
                                        n_mode  = bps_pkg::MODE_IDLE;
                                        n_level = 1'b0;
                                    end else begin
                                        n_rep   = rep_dec;
                                        n_seg   = 2'd0;
                                        n_level = 1'b1;
                                        n_cd    = dur(bps_pkg::MS_100);
                                    end
                                end
                                bps_pkg::PAT_SOS: begin
                                    if (r_level) begin
                                        n_level = 1'b0;
                                        if (inner_inc >= bps_pkg::SOS_SYMBOLS) begin
                                            // letter gap
                                            n_cd    = dur(bps_pkg::MS_300);
                                            n_inner = '0;
                                            n_outer = outer_inc;
                                            if (outer_inc >= bps_pkg::SOS_LETTERS) begin
                                                if (last_pass) begin
                                                    n_mode = bps_pkg::MODE_IDLE;
                                                end else begin
                                                    n_rep   = rep_dec;
                                                    n_outer = '0;
                                                end
                                            end
                                        end else begin
                                            n_cd    = dur(bps_pkg::MS_100);
                                            n_inner = inner_inc;
                                        end
                                    end else begin
                                        // dashes in the middle letter
                                        n_level = 1'b1;
                                        n_cd    = (r_outer != 4'd1) ?
                                                  dur(bps_pkg::MS_100) :
                                                  dur(bps_pkg::MS_300);
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
            end
            bps_pkg::KIND_BLINK: begin
                n_mode  = bps_pkg::MODE_BLINK;
                n_on_t  = DURATION_BITS'(i_beat.on_time);
                n_off_t = DURATION_BITS'(i_beat.off_time);
                n_rep   = REPEAT_BITS'(i_beat.repeat_count);
                n_seg   = 2'd0;
                n_level = 1'b1;
                n_cd    = DURATION_BITS'(i_beat.on_time);
            end
            bps_pkg::KIND_PRESET: begin
                if (i_beat.pattern < bps_pkg::PAT_COUNT) begin
                    n_mode  = bps_pkg::MODE_PRESET;
                    n_pat   = i_beat.pattern;
                    n_rep   = REPEAT_BITS'(i_beat.repeat_count);
                    n_seg   = 2'd0;
                    n_inner = '0;
                    n_outer = '0;
                    n_level = 1'b1;
                    n_cd    = dur(bps_pkg::first_on_ms(i_beat.pattern));
                end
            end
            bps_pkg::KIND_STOP: begin
                if (r_mode != bps_pkg::MODE_IDLE) begin
                    n_mode  = bps_pkg::MODE_IDLE;
                    n_level = 1'b0;
                end
            end
            bps_pkg::KIND_FORCE_ON: begin
                n_level = 1'b1;
            end
            bps_pkg::KIND_FORCE_OFF: begin
                n_level = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // result from the updated state
    assign o_res.pin_level = n_level ? i_active_level : !i_active_level;
    assign o_res.sounding  = n_level;
    assign o_res.busy_res  = (n_mode != bps_pkg::MODE_IDLE);

    // state update once per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= bps_pkg::MODE_IDLE;
            r_level <= 1'b0;
            r_cd    <= '0;
            r_rep   <= '0;
            r_on_t  <= '0;
            r_off_t <= '0;
            r_pat   <= '0;
            r_seg   <= '0;
            r_inner <= '0;
            r_outer <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_level <= n_level;
            r_cd    <= n_cd;
            r_rep   <= n_rep;
            r_on_t  <= n_on_t;
            r_off_t <= n_off_t;
            r_pat   <= n_pat;
            r_seg   <= n_seg;
            r_inner <= n_inner;
            r_outer <= n_outer;
        end
    end

endmodule
